[hdl/cvbu_pkg.sv]
// Shared widths, angle constants and the arctangent table for the camera view basis block.
// No dependencies; the top level and cvbu_mul refer to it by scoped names.
package cvbu_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int TRIG_STEPS_DEF = 16;
  localparam int ANG_FRAC       = 24;

  localparam int OPW = 33;
  localparam int PRW = 2 * OPW;

  function automatic logic [30:0] atan_deg_q24(input logic [4:0] idx);
    case (idx)
      5'd0:  return 31'd754974720;
      5'd1:  return 31'd445687602;
      5'd2:  return 31'd235489089;
      5'd3:  return 31'd119537938;
      5'd4:  return 31'd60000934;
      5'd5:  return 31'd30029717;
      5'd6:  return 31'd15018523;
      5'd7:  return 31'd7509719;
      5'd8:  return 31'd3754917;
      5'd9:  return 31'd1877466;
      5'd10: return 31'd938734;
      5'd11: return 31'd469367;
      5'd12: return 31'd234684;
      5'd13: return 31'd117342;
      5'd14: return 31'd58671;
      5'd15: return 31'd29336;
      5'd16: return 31'd14668;
      5'd17: return 31'd7334;
      5'd18: return 31'd3667;
      5'd19: return 31'd1833;
      5'd20: return 31'd917;
      5'd21: return 31'd458;
      5'd22: return 31'd229;
      5'd23: return 31'd115;
      default: return 31'd0;
    endcase
  endfunction

endpackage

[hdl/camera_view_basis_update.sv]
// Camera view basis: eye point, basis u v n and the 3x4 view matrix per request.
// Top level with the sequencer, angle reduction and CORDIC; uses cvbu_pkg,
// cvbu_mul, cvbu_div and cvbu_sqrt.
//
//  channel | direction | handshake              | payload
//  in      | slave     | in_tvalid / in_tready   | in_tuser mode, in_tdata three arguments
//  out     | master    | out_tvalid / out_tready | out_tdata view matrix, 12 words
//
// The time a request takes depends on its mode; the shared multiplier, the square root
// and the bit-serial divider set it.
// Reset clears the eye, look and basis vectors and the control; in_tready is high only when idle.
// A result waits in the output register; the next request is taken meanwhile.
module camera_view_basis_update #(
  parameter int FRAC_BITS  = cvbu_pkg::FRAC_BITS_DEF,
  parameter int TRIG_STEPS = cvbu_pkg::TRIG_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // arg_first, arg_second, arg_third
  input  logic [2:0]   in_tuser,   // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [383:0] out_tdata   // ux uy uz vx vy vz nx ny nz trans_u trans_v trans_n
);

  localparam int OPW       = cvbu_pkg::OPW;
  localparam int PRW       = cvbu_pkg::PRW;
  localparam int ANG_W     = 32 + cvbu_pkg::ANG_FRAC - FRAC_BITS;
  localparam int RED_STEPS = (ANG_W > 33) ? ANG_W - 33 : 0;
  localparam int RED_LAST  = (RED_STEPS > 0) ? RED_STEPS - 1 : 0;
  localparam int NUM_W     = 32 + FRAC_BITS;
  localparam int DIV_ITER  = FRAC_BITS + 2;

  localparam logic [2:0] MODE_EYE   = 3'd0;
  localparam logic [2:0] MODE_LOOK  = 3'd1;
  localparam logic [2:0] MODE_BASIS = 3'd2;
  localparam logic [2:0] MODE_SLIDE = 3'd3;
  localparam logic [2:0] MODE_ROLL  = 3'd4;
  localparam logic [2:0] MODE_PITCH = 3'd5;
  localparam logic [2:0] MODE_YAW   = 3'd6;

  localparam logic [63:0]        TURN64  = 64'd6039797760;
  localparam logic signed [34:0] TURN    = 35'sd6039797760;
  localparam logic signed [34:0] HALF    = 35'sd3019898880;
  localparam logic signed [34:0] QUARTER = 35'sd1509949440;
  localparam logic signed [OPW-1:0] GAIN = 33'sd652032874;
  localparam logic signed [PRW-1:0] HALF_F = PRW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PRW-1:0] HALF_30 = PRW'(1) <<< 29;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_REDUCE = 13'b0000000000010,
    S_FOLD   = 13'b0000000000100,
    S_CORDIC = 13'b0000000001000,
    S_FLIP   = 13'b0000000010000,
    S_MAC    = 13'b0000000100000,
    S_NMAX   = 13'b0000001000000,
    S_NSHIFT = 13'b0000010000000,
    S_SQGO   = 13'b0000100000000,
    S_SQWAIT = 13'b0001000000000,
    S_DVGO   = 13'b0010000000000,
    S_DVWAIT = 13'b0100000000000,
    S_FIN    = 13'b1000000000000
  } state_t;

  typedef enum logic [2:0] {
    J_SLIDE, J_TRANS, J_ROT, J_CRU, J_CRV, J_SQ
  } job_t;

  state_t state_r;
  job_t   job_r;

  logic signed [31:0] eye_r [3];
  logic signed [31:0] look_r [3];
  logic signed [31:0] bu_r [3];
  logic signed [31:0] bv_r [3];
  logic signed [31:0] bn_r [3];
  logic signed [31:0] tr_r [3];
  logic signed [63:0] tv_r [3];
  logic signed [63:0] wv_r [3];

  logic [2:0]         mode_r;
  logic signed [31:0] a_r, b_r, c_r;
  logic [1:0]         k_r;
  logic [4:0]         cnt_r;
  logic               ph_r;
  logic               tgt_r;
  logic               neg_r;
  logic               flip_r;
  logic [ANG_W-1:0]   mag_r;
  logic signed [34:0] ang_r;
  logic signed [OPW-1:0] x_r, y_r;
  logic signed [PRW-1:0] acc_r;
  logic signed [31:0] na_r;
  logic [63:0]        mm_r;
  logic [63:0]        sumsq_r;
  logic [31:0]        len_r;
  logic               out_valid_r;
  logic [383:0]       out_data_r;

  logic signed [OPW-1:0] opa, opb;
  logic                  opneg;
  logic signed [PRW-1:0] prod;
  logic signed [PRW-1:0] pterm, acc_nxt, rnd_f, rnd_30;
  logic [1:0]            kp1, kp2, jj;
  logic [4:0]            jmax;
  logic [1:0]            kmax;
  logic signed [31:0]    rot_ak, rot_bk;
  logic signed [31:0]    up_v [3];

  logic signed [ANG_W-1:0] ang_in;
  logic [ANG_W-1:0]        turn_sh;
  logic signed [34:0]      rr0, rr1;
  logic signed [OPW-1:0]   dx, dy;
  logic signed [34:0]      at;

  logic [63:0]        abs_t;
  logic [63:0]        mm_nxt;
  logic [63:0]        wabs;
  logic [NUM_W-1:0]   div_num;
  logic               sq_start, sq_done, dv_start, dv_done;
  logic [31:0]        sq_root;
  logic [DIV_ITER-1:0] dv_quo;
  logic signed [31:0] q32;
  logic               accept, load_out;

  function automatic logic [1:0] inc3(input logic [1:0] k);
    case (k)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PRW-1:0] v);
    if ((&v[PRW-1:31]) || !(|v[PRW-1:31])) return v[31:0];
    return v[PRW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  assign accept = in_tvalid && (state_r == S_IDLE);

  cvbu_mul u_mul (.clk(clk), .op_a(opa), .op_b(opb), .prod(prod));

  cvbu_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .rad(sumsq_r),
    .done(sq_done), .root(sq_root)
  );

  cvbu_div #(.NUM_W(NUM_W), .ITER(DIV_ITER)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(div_num), .den(len_r),
    .done(dv_done), .quo(dv_quo)
  );

  assign sq_start = (state_r == S_SQGO);
  assign dv_start = (state_r == S_DVGO);

  assign up_v[0] = a_r;
  assign up_v[1] = b_r;
  assign up_v[2] = c_r;

  always_comb begin
    kp1 = inc3(k_r);
    kp2 = inc3(kp1);
    jj  = cnt_r[1:0];
    case (mode_r)
      MODE_ROLL: begin
        rot_ak = bu_r[k_r];
        rot_bk = bv_r[k_r];
      end
      MODE_PITCH: begin
        rot_ak = bv_r[k_r];
        rot_bk = bn_r[k_r];
      end
      default: begin
        rot_ak = bn_r[k_r];
        rot_bk = bu_r[k_r];
      end
    endcase
    opa   = '0;
    opb   = '0;
    opneg = 1'b0;
    jmax  = 5'd2;
    kmax  = 2'd2;
    case (job_r)
      J_SLIDE: begin
        case (jj)
          2'd0: begin
            opa = OPW'(a_r);
            opb = OPW'(bu_r[k_r]);
          end
          2'd1: begin
            opa = OPW'(b_r);
            opb = OPW'(bv_r[k_r]);
          end
          default: begin
            opa = OPW'(c_r);
            opb = OPW'(bn_r[k_r]);
          end
        endcase
      end
      J_TRANS: begin
        opa = OPW'(eye_r[jj]);
        case (k_r)
          2'd0:    opb = OPW'(bu_r[jj]);
          2'd1:    opb = OPW'(bv_r[jj]);
          default: opb = OPW'(bn_r[jj]);
        endcase
      end
      J_ROT: begin
        jmax = 5'd3;
        case (jj)
          2'd0: begin
            opa = x_r;
            opb = OPW'(rot_ak);
          end
          2'd1: begin
            opa   = y_r;
            opb   = OPW'(rot_bk);
            opneg = 1'b1;
          end
          2'd2: begin
            opa = y_r;
            opb = OPW'(rot_ak);
          end
          default: begin
            opa = x_r;
            opb = OPW'(rot_bk);
          end
        endcase
      end
      J_CRU: begin
        jmax = 5'd1;
        if (jj == 2'd0) begin
          opa = OPW'(up_v[kp1]);
          opb = OPW'(bn_r[kp2]);
        end else begin
          opa   = OPW'(up_v[kp2]);
          opb   = OPW'(bn_r[kp1]);
          opneg = 1'b1;
        end
      end
      J_CRV: begin
        jmax = 5'd1;
        if (jj == 2'd0) begin
          opa = OPW'(bn_r[kp1]);
          opb = OPW'(bu_r[kp2]);
        end else begin
          opa   = OPW'(bn_r[kp2]);
          opb   = OPW'(bu_r[kp1]);
          opneg = 1'b1;
        end
      end
      default: begin
        kmax = 2'd0;
        opa  = wv_r[jj][OPW-1:0];
        opb  = wv_r[jj][OPW-1:0];
      end
    endcase
  end

  always_comb begin
    pterm = opneg ? -prod : prod;
    if (cnt_r == 5'd0 || (job_r == J_ROT && cnt_r == 5'd2)) acc_nxt = pterm;
    else acc_nxt = acc_r + pterm;
    rnd_f  = (acc_nxt + HALF_F) >>> FRAC_BITS;
    rnd_30 = (acc_nxt + HALF_30) >>> 30;
  end

  always_comb begin
    ang_in  = ANG_W'($signed(in_tdata[31:0])) <<< (cvbu_pkg::ANG_FRAC - FRAC_BITS);
    turn_sh = ANG_W'(TURN64 << cnt_r);
    rr0 = (neg_r && mag_r != '0) ? TURN - $signed(35'(mag_r)) : $signed(35'(mag_r));
    rr1 = (rr0 >= HALF) ? rr0 - TURN : rr0;
    dx  = y_r >>> cnt_r;
    dy  = x_r >>> cnt_r;
    at  = $signed({4'b0000, cvbu_pkg::atan_deg_q24(cnt_r)});
  end

  always_comb begin
    abs_t   = tv_r[k_r][63] ? 64'(-tv_r[k_r]) : 64'(tv_r[k_r]);
    mm_nxt  = (k_r == 2'd0 || abs_t > mm_r) ? abs_t : mm_r;
    wabs    = wv_r[k_r][63] ? 64'(-wv_r[k_r]) : 64'(wv_r[k_r]);
    div_num = (NUM_W'(wabs[30:0]) << FRAC_BITS) + NUM_W'(len_r[31:1]);
    q32     = 32'(dv_quo);
    if (wv_r[k_r][63]) q32 = -q32;
  end

  assign load_out = (state_r == S_FIN) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      job_r       <= J_TRANS;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      cnt_r       <= '0;
      ph_r        <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        eye_r[i]  <= '0;
        look_r[i] <= '0;
        bu_r[i]   <= '0;
        bv_r[i]   <= '0;
        bn_r[i]   <= '0;
      end
    end else begin
      if (load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            mode_r <= in_tuser;
            a_r    <= in_tdata[31:0];
            b_r    <= in_tdata[63:32];
            c_r    <= in_tdata[95:64];
            k_r    <= '0;
            cnt_r  <= '0;
            ph_r   <= 1'b0;
            job_r  <= J_TRANS;
            state_r <= S_MAC;
            case (in_tuser)
              MODE_EYE: begin
                eye_r[0] <= in_tdata[31:0];
                eye_r[1] <= in_tdata[63:32];
                eye_r[2] <= in_tdata[95:64];
              end
              MODE_LOOK: begin
                look_r[0] <= in_tdata[31:0];
                look_r[1] <= in_tdata[63:32];
                look_r[2] <= in_tdata[95:64];
              end
              MODE_BASIS: begin
                for (int i = 0; i < 3; i++) tv_r[i] <= 64'(eye_r[i]) - 64'(look_r[i]);
                tgt_r   <= 1'b0;
                state_r <= S_NMAX;
              end
              MODE_SLIDE: job_r <= J_SLIDE;
              MODE_ROLL, MODE_PITCH, MODE_YAW: begin
                neg_r   <= in_tdata[31];
                mag_r   <= in_tdata[31] ? ANG_W'(-ang_in) : ANG_W'(ang_in);
                cnt_r   <= 5'(RED_LAST);
                state_r <= (RED_STEPS > 0) ? S_REDUCE : S_FOLD;
              end
              default: job_r <= J_TRANS;
            endcase
          end
        end

        S_REDUCE: begin
          if (mag_r >= turn_sh) mag_r <= mag_r - turn_sh;
          if (cnt_r == 5'd0) state_r <= S_FOLD;
          else cnt_r <= cnt_r - 5'd1;
        end

        S_FOLD: begin
          if (rr1 > QUARTER) begin
            ang_r  <= rr1 - HALF;
            flip_r <= 1'b1;
          end else if (rr1 < -QUARTER) begin
            ang_r  <= rr1 + HALF;
            flip_r <= 1'b1;
          end else begin
            ang_r  <= rr1;
            flip_r <= 1'b0;
          end
          x_r     <= GAIN;
          y_r     <= '0;
          cnt_r   <= '0;
          state_r <= S_CORDIC;
        end

        S_CORDIC: begin
          if (ang_r >= 0) begin
            x_r   <= x_r - dx;
            y_r   <= y_r + dy;
            ang_r <= ang_r - at;
          end else begin
            x_r   <= x_r + dx;
            y_r   <= y_r - dy;
            ang_r <= ang_r + at;
          end
          if (cnt_r == 5'(TRIG_STEPS - 1)) state_r <= S_FLIP;
          else cnt_r <= cnt_r + 5'd1;
        end

        S_FLIP: begin
          if (flip_r) begin
            x_r <= -x_r;
            y_r <= -y_r;
          end
          job_r   <= J_ROT;
          k_r     <= '0;
          cnt_r   <= '0;
          ph_r    <= 1'b0;
          state_r <= S_MAC;
        end

        S_MAC: begin
          ph_r <= ~ph_r;
          if (ph_r) begin
            acc_r <= acc_nxt;
            if (job_r == J_ROT && cnt_r == 5'd1) na_r <= sat32(rnd_30);
            if (cnt_r == jmax) begin
              case (job_r)
                J_SLIDE: eye_r[k_r] <= sat32(PRW'(eye_r[k_r]) + rnd_f);
                J_TRANS: tr_r[k_r] <= sat32(-rnd_f);
                J_ROT: begin
                  case (mode_r)
                    MODE_ROLL: begin
                      bu_r[k_r] <= na_r;
                      bv_r[k_r] <= sat32(rnd_30);
                    end
                    MODE_PITCH: begin
                      bv_r[k_r] <= na_r;
                      bn_r[k_r] <= sat32(rnd_30);
                    end
                    default: begin
                      bn_r[k_r] <= na_r;
                      bu_r[k_r] <= sat32(rnd_30);
                    end
                  endcase
                end
                J_CRU: tv_r[k_r] <= acc_nxt[63:0];
                J_CRV: bv_r[k_r] <= sat32(rnd_f);
                default: sumsq_r <= acc_nxt[63:0];
              endcase
              cnt_r <= '0;
              if (k_r == kmax) begin
                k_r <= '0;
                case (job_r)
                  J_TRANS: state_r <= S_FIN;
                  J_CRU: begin
                    tgt_r   <= 1'b1;
                    state_r <= S_NMAX;
                  end
                  J_SQ: state_r <= S_SQGO;
                  default: job_r <= J_TRANS;
                endcase
              end else begin
                k_r <= k_r + 2'd1;
              end
            end else begin
              cnt_r <= cnt_r + 5'd1;
            end
          end
        end

        S_NMAX: begin
          mm_r <= mm_nxt;
          if (k_r == 2'd2) begin
            k_r <= '0;
            if (mm_nxt == '0) begin
              for (int i = 0; i < 3; i++) begin
                if (tgt_r) bu_r[i] <= '0;
                else bn_r[i] <= '0;
              end
              job_r   <= tgt_r ? J_CRV : J_CRU;
              cnt_r   <= '0;
              ph_r    <= 1'b0;
              state_r <= S_MAC;
            end else begin
              for (int i = 0; i < 3; i++) wv_r[i] <= tv_r[i];
              state_r <= S_NSHIFT;
            end
          end else begin
            k_r <= k_r + 2'd1;
          end
        end

        S_NSHIFT: begin
          if (mm_r >= 64'h4000_0000) begin
            mm_r <= mm_r >> 1;
            for (int i = 0; i < 3; i++) wv_r[i] <= wv_r[i] >>> 1;
          end else if (mm_r < 64'h2000_0000) begin
            mm_r <= mm_r << 1;
            for (int i = 0; i < 3; i++) wv_r[i] <= wv_r[i] <<< 1;
          end else begin
            job_r   <= J_SQ;
            k_r     <= '0;
            cnt_r   <= '0;
            ph_r    <= 1'b0;
            state_r <= S_MAC;
          end
        end

        S_SQGO: state_r <= S_SQWAIT;

        S_SQWAIT: begin
          if (sq_done) begin
            len_r   <= sq_root;
            k_r     <= '0;
            state_r <= S_DVGO;
          end
        end

        S_DVGO: state_r <= S_DVWAIT;

        S_DVWAIT: begin
          if (dv_done) begin
            if (tgt_r) bu_r[k_r] <= q32;
            else bn_r[k_r] <= q32;
            if (k_r == 2'd2) begin
              k_r     <= '0;
              job_r   <= tgt_r ? J_CRV : J_CRU;
              cnt_r   <= '0;
              ph_r    <= 1'b0;
              state_r <= S_MAC;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= S_DVGO;
            end
          end
        end

        S_FIN: begin
          if (load_out) state_r <= S_IDLE;
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {tr_r[2], tr_r[1], tr_r[0], bn_r[2], bn_r[1], bn_r[0],
                     bv_r[2], bv_r[1], bv_r[0], bu_r[2], bu_r[1], bu_r[0]};
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[hdl/cvbu_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on cvbu_pkg for operand and product widths.
module cvbu_mul (
  input  logic                             clk,
  input  logic signed [cvbu_pkg::OPW-1:0]  op_a,
  input  logic signed [cvbu_pkg::OPW-1:0]  op_b,
  output logic signed [cvbu_pkg::PRW-1:0]  prod
);

  logic signed [cvbu_pkg::PRW-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

[hdl/cvbu_div.sv]
// Restoring unsigned divider, one quotient bit per cycle, for the normalize step.
// Standalone; the caller guarantees the quotient fits in ITER bits.
module cvbu_div #(
  parameter int NUM_W = 48,
  parameter int ITER  = 18
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [31:0]      den,
  output logic             done,
  output logic [ITER-1:0]  quo
);

  localparam int CW = $clog2(ITER + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   rem_r;
  logic [ITER-1:0] nq_r;
  logic [32:0]   trial;
  logic          ge;

  assign trial = {rem_r, nq_r[ITER-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(ITER - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 32'(num >> ITER);
      nq_r  <= num[ITER-1:0];
    end else if (busy_r) begin
      rem_r <= ge ? 32'(trial - {1'b0, den}) : trial[31:0];
      nq_r  <= {nq_r[ITER-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = nq_r;

endmodule

[hdl/cvbu_sqrt.sv]
// Integer square root, two radicand bits per cycle.
// Standalone; used for the vector length in the normalize step.
module cvbu_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] rad,
  output logic        done,
  output logic [31:0] root
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [63:0] x_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= rad;
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_r   <= x_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule
